/* hw/rtl/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Holds the register map, the configuration bundle and the item/result
// records that pass between the scanner's modules.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MaxPatternDef = 16;   // default pattern window
  localparam int unsigned PatBytes      = 16;   // pattern bytes with a compare value
  localparam int unsigned AddrW         = 32;
  localparam int unsigned CntW          = 33;   // bytes taken, up to scan length + window
  localparam int unsigned SkipW         = 16;
  localparam int unsigned PlenW         = 5;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [AddrW-1:0] ScanLenRst = 32'h0050_0000;
  localparam logic [PlenW-1:0] PlenRst    = 5'd1;

  typedef enum logic [CfgIdxW-1:0] {
    RegBaseAddr   = 3'd0,
    RegScanLen    = 3'd1,
    RegPatLow     = 3'd2,
    RegPatHigh    = 3'd3,
    RegCareMask   = 3'd4,
    RegPatLen     = 3'd5,
    RegSkipCount  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [AddrW-1:0]      base_address;
    logic [AddrW-1:0]      scan_length;
    logic [8*PatBytes-1:0] pattern;        // byte j in bits 8j+7:8j
    logic [PatBytes-1:0]   care_mask;
    logic [PlenW-1:0]      pattern_length;
    logic [SkipW-1:0]      skip_count;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [AddrW-1:0] match_address;
  } result_t;

endpackage

/* hw/rtl/mbps_cfg.sv */
// ----------------------------------------------------------------------------
// mbps_cfg: configuration register file
// Decodes indexed writes into the scanner's setup registers.
// ----------------------------------------------------------------------------
module mbps_cfg import mbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_reg_e'(wr_index_i))
        RegBaseAddr:  cfg_d.base_address         = wr_data_i[AddrW-1:0];
        RegScanLen:   cfg_d.scan_length          = wr_data_i[AddrW-1:0];
        RegPatLow:    cfg_d.pattern[63:0]        = wr_data_i;
        RegPatHigh:   cfg_d.pattern[127:64]      = wr_data_i;
        RegCareMask:  cfg_d.care_mask            = wr_data_i[PatBytes-1:0];
        RegPatLen:    cfg_d.pattern_length       = wr_data_i[PlenW-1:0];
        RegSkipCount: cfg_d.skip_count           = wr_data_i[SkipW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base_address:   '0,
                 scan_length:    ScanLenRst,
                 pattern:        '0,
                 care_mask:      '0,
                 pattern_length: PlenRst,
                 skip_count:     '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/mbps_scan.sv */
// ----------------------------------------------------------------------------
// mbps_scan: window, counters and masked compare
// Judges the window that ends at the current byte and updates scan state.
// ----------------------------------------------------------------------------
module mbps_scan import mbps_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam int unsigned WinDepth = (MaxPattern > 1) ? MaxPattern - 1 : 1;
  localparam int unsigned LenW     = $clog2(MaxPattern + 1);
  localparam int unsigned SelW     = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned CmpBytes = (MaxPattern < PatBytes) ? MaxPattern : PatBytes;

  logic [7:0]       window_q [WinDepth];
  logic [7:0]       window_d [WinDepth];
  logic [CntW-1:0]  bytes_q, bytes_d;
  logic [SkipW-1:0] matches_q, matches_d;
  logic             done_q, done_d;

  logic [LenW-1:0]  len;
  logic [7:0]       seq [MaxPattern];   // seq[0] is the current byte, then older
  logic             hit;

  logic [CntW-1:0]  bytes_cur, bytes_n, start_off;
  logic [SkipW-1:0] matches_cur;
  logic             done_cur, len_zero, in_range, last_start, matched, take;

  // Clamp the pattern length into 1..MaxPattern.
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len = LenW'(1);
    end else if (32'(cfg_i.pattern_length) > 32'(MaxPattern)) begin
      len = LenW'(MaxPattern);
    end else begin
      len = LenW'(cfg_i.pattern_length);
    end
  end

  always_comb begin
    seq[0] = item_i.data_byte;
    for (int k = 1; k < MaxPattern; k++) begin
      seq[k] = window_q[k-1];
    end
  end

  // Pattern byte j lines up with the byte len-1-j positions back.
  always_comb begin
    logic [LenW-1:0] pos;
    hit = 1'b1;
    for (int j = 0; j < CmpBytes; j++) begin
      pos = len - LenW'(1) - LenW'(j);
      if ((LenW'(j) < len) && cfg_i.care_mask[j] &&
          (seq[pos[SelW-1:0]] != cfg_i.pattern[8*j +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    bytes_cur   = item_i.first ? '0 : bytes_q;
    matches_cur = item_i.first ? '0 : matches_q;
    done_cur    = item_i.first ? 1'b0 : done_q;
    bytes_n     = bytes_cur + CntW'(1);
    start_off   = bytes_n - CntW'(len);
    len_zero    = (cfg_i.scan_length == '0);
    in_range    = (bytes_n >= CntW'(len)) && (start_off < CntW'(cfg_i.scan_length));
    last_start  = (start_off + CntW'(1)) == CntW'(cfg_i.scan_length);
    matched     = in_range && hit;
    take        = matched && (matches_cur >= cfg_i.skip_count);

    result_o.valid = item_i.valid && !done_cur &&
                     (len_zero || take || (in_range && last_start) || item_i.last);
    result_o.found = !len_zero && take;
    result_o.match_address = result_o.found ?
                             cfg_i.base_address + start_off[AddrW-1:0] : '0;
  end

  always_comb begin
    bytes_d   = bytes_q;
    matches_d = matches_q;
    done_d    = done_q;
    window_d  = window_q;
    if (item_i.valid && !done_cur) begin
      bytes_d     = bytes_n;
      matches_d   = (matched && !take) ? matches_cur + SkipW'(1) : matches_cur;
      done_d      = result_o.valid;
      window_d[0] = item_i.data_byte;
      for (int k = 1; k < WinDepth; k++) begin
        window_d[k] = item_i.first ? 8'h00 : window_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q   <= '0;
      matches_q <= '0;
      done_q    <= 1'b1;
    end else begin
      bytes_q   <= bytes_d;
      matches_q <= matches_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
  end

endmodule

/* hw/rtl/masked_byte_pattern_scanner.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: byte stream search for a masked pattern
// Path: an accepted byte waits in the input register and is judged as it moves on;
//   its result is loaded into the result register and appears on the master side.
//   A stalled result register keeps the next byte waiting in the input register.
// Throughput: one byte per cycle while results are taken on the master side;
//   the masked compare over the window and the offset compare set the pace.
// Reset: asynchronous, active low; the scanner comes up idle, ignoring bytes
//   until one flagged first, with the registers at their documented values.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner import mbps_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,    // [7:0] data_byte
  input  logic                s_axis_tuser,    // [0] first
  input  logic                s_axis_tlast,    // last byte of the scan
  // search result out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [AddrW-1:0]    m_axis_tdata,    // [31:0] match_address
  output logic                m_axis_tuser,    // [0] found
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   scan_item;
  result_t scan_res;

  // Input register: holds one accepted byte until the scan core takes it.
  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       in_first_q, in_last_q;

  // Result register: parts the core from a stalled consumer.
  logic             out_v_q, out_v_d;
  logic             out_found_q;
  logic [AddrW-1:0] out_addr_q;

  logic advance;
  logic in_xfer;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  mbps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held byte whenever the result register is free or draining.
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    scan_item.valid     = advance;
    scan_item.data_byte = in_byte_q;
    scan_item.first     = in_first_q;
    scan_item.last      = in_last_q;
  end

  mbps_scan #(
    .MaxPattern (MaxPattern)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (scan_item),
    .result_o (scan_res)
  );

  always_comb begin
    in_v_d = in_v_q;
    if (in_xfer) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
  end

  // Load a new result on advance; otherwise drop the old one once transferred.
  always_comb begin
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = scan_res.valid;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
    if (advance && scan_res.valid) begin
      out_found_q <= scan_res.found;
      out_addr_q  <= scan_res.match_address;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = out_addr_q;

endmodule

/* hw/rtl/mbps_checker.sv */
// ----------------------------------------------------------------------------
// mbps_checker: port-level checks for the masked byte pattern scanner
// Watches the stream ports and flags ordering and backpressure slips.
// ----------------------------------------------------------------------------
module mbps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A failed search reports a zero address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("not-found result with nonzero address");

  // A fresh result follows an earlier input transfer.
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a causing byte");

  // Input backpressure only comes from a stalled result.
  a_bp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output free");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: masked byte pattern scanner
// Streams byte scans into the scanner and checks every search report against
// a cycle-free scoreboard model of the masked window compare. A directed
// block covers register resets, the length clamps, zero and one-entry scan
// ranges, the skip counter and one-byte scans. Random phases follow, each
// with a fresh register setting and scans seeded with copies of the pattern.
// ----------------------------------------------------------------------------
module testbench;
  import mbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget    = 870;   // directed bytes plus random
  localparam int unsigned CalmMargin    = 150;   // tail of the run without idling
  localparam int unsigned SettleCycles  = 8;     // lets the input and result registers run dry
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxScanBytes  = 160;

  // index with no register behind it; writes to it must change nothing
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } scan_byte_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] data_byte
  logic                s_axis_tuser  = 1'b0; // [0] first
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [AddrW-1:0]    m_axis_tdata;         // [31:0] match_address
  logic                m_axis_tuser;         // [0] found
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  masked_byte_pattern_scanner uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model: register shadows and scan state
  // --------------------------------------------------------------------------
  logic [AddrW-1:0]      cfg_base     = '0;
  logic [AddrW-1:0]      cfg_scan_len = ScanLenRst;
  logic [8*PatBytes-1:0] cfg_pattern  = '0;
  logic [PatBytes-1:0]   cfg_care     = '0;
  logic [PlenW-1:0]      cfg_plen     = PlenRst;
  logic [SkipW-1:0]      cfg_skip     = '0;

  logic [7:0]      window_hist [MaxPatternDef-1];  // [0] holds the newest earlier byte
  longint unsigned bytes_in_scan  = 0;
  int unsigned     matches_passed = 0;
  bit              scan_idle      = 1'b1;

  report_t     pending_reports [$];
  scan_byte_t  byte_queue [$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned fail_count   = 0;

  // idling knobs, set per phase
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          calm      = 1'b0;

  function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
    case (idx)
      RegBaseAddr:  cfg_base     = data[AddrW-1:0];
      RegScanLen:   cfg_scan_len = data[AddrW-1:0];
      RegPatLow:    cfg_pattern[63:0]   = data;
      RegPatHigh:   cfg_pattern[127:64] = data;
      RegCareMask:  cfg_care     = data[PatBytes-1:0];
      RegPatLen:    cfg_plen     = data[PlenW-1:0];
      RegSkipCount: cfg_skip     = data[SkipW-1:0];
      default: ;
    endcase
  endfunction

  // bytes past the compare table and uncared bytes always pass
  function automatic bit byte_fits(input int unsigned j, input logic [7:0] b);
    if (j >= PatBytes) return 1'b1;
    if (!cfg_care[j]) return 1'b1;
    return b == cfg_pattern[8*j +: 8];
  endfunction

  function automatic void report(input logic found, input logic [AddrW-1:0] addr);
    report_t r;
    r.found         = found;
    r.match_address = addr;
    pending_reports.push_back(r);
    scan_idle = 1'b1;
  endfunction

  // Advance the model by one accepted byte and queue any report it causes.
  function automatic void scan_step(input logic [7:0] b, input logic first,
                                    input logic last);
    int unsigned     len;
    int unsigned     i;
    longint unsigned start;
    logic [AddrW-1:0] ofs;
    bit              hit;
    len = (cfg_plen == 0) ? 1 : ((cfg_plen > MaxPatternDef) ? MaxPatternDef : cfg_plen);
    if (first) begin
      for (i = 0; i < MaxPatternDef - 1; i++) window_hist[i] = '0;
      bytes_in_scan  = 0;
      matches_passed = 0;
      scan_idle      = 1'b0;
    end
    if (scan_idle) return;
    bytes_in_scan++;
    if (cfg_scan_len == 0) begin
      report(1'b0, '0);
      return;
    end
    // judge the window that this byte completes, if it starts in range
    if (bytes_in_scan >= len) begin
      start = bytes_in_scan - len;
      if (start < longint'(cfg_scan_len)) begin
        hit = byte_fits(len - 1, b);
        for (i = 0; i + 1 < len; i++) begin
          if (!byte_fits(i, window_hist[len - 2 - i])) hit = 1'b0;
        end
        if (hit) begin
          if (matches_passed >= cfg_skip) begin
            ofs = start[AddrW-1:0];
            report(1'b1, cfg_base + ofs);
            return;
          end
          matches_passed++;
        end
        if (start + 1 >= longint'(cfg_scan_len)) begin
          report(1'b0, '0);
          return;
        end
      end
    end
    for (i = MaxPatternDef - 2; i > 0; i--) window_hist[i] = window_hist[i-1];
    window_hist[0] = b;
    if (last) report(1'b0, '0);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample every channel at the rising edge
  // --------------------------------------------------------------------------
  bit          byte_xfer = 1'b0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    report_t want;
    byte_xfer <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_register(cfg_index_i, cfg_data_i);

      // compare a delivered report against the oldest one predicted
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_reports.size() == 0) begin
          $error("report with none pending: found=%0b match_address=%h",
                 m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          if (m_axis_tuser !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata !== want.match_address) begin
            $error("match_address: expected %h, got %h", want.match_address, m_axis_tdata);
            fail_count++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        scan_step(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        bytes_taken++;
      end

      // watchdog: give up after a long stretch without any transfer
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("FAIL masked_byte_pattern_scanner");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: byte stream and result backpressure, updated at the falling edge
  // --------------------------------------------------------------------------
  int unsigned src_gap  = 0;
  int unsigned sink_gap = 0;

  always @(negedge clk_i) begin
    scan_byte_t nxt;
    if (rst_ni) begin
      // load the next byte only once the current one is gone
      if (!s_axis_tvalid || byte_xfer) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_queue.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(99) < gap_pct) begin
          src_gap <= $urandom_range(8, 0);
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = byte_queue.pop_front();
          s_axis_tdata  <= nxt.data_byte;
          s_axis_tuser  <= nxt.first;
          s_axis_tlast  <= nxt.last;
          s_axis_tvalid <= 1'b1;
        end
      end

      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        sink_gap <= $urandom_range(8, 0);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic first, input logic last);
    scan_byte_t s;
    s.data_byte = b;
    s.first     = first;
    s.last      = last;
    byte_queue.push_back(s);
    bytes_queued++;
  endtask

  // Hold valid until the write is taken; the caller drops it after a batch.
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  // Write every register; with garble set, fill the unused upper bits with
  // noise and sometimes hit the unmapped index.
  task automatic program_scan(input logic [AddrW-1:0] base, input logic [AddrW-1:0] slen,
                              input logic [63:0] plo, input logic [63:0] phi,
                              input logic [PatBytes-1:0] care,
                              input logic [PlenW-1:0] plen,
                              input logic [SkipW-1:0] skip, input bit garble);
    logic [CfgDataW-1:0] junk;
    junk = garble ? {$urandom, $urandom} : '0;
    write_register(RegBaseAddr,  {junk[63:AddrW], base});
    write_register(RegScanLen,   {junk[63:AddrW], slen});
    write_register(RegPatLow,    plo);
    write_register(RegPatHigh,   phi);
    write_register(RegCareMask,  {junk[63:PatBytes], care});
    write_register(RegPatLen,    {junk[63:PlenW], plen});
    write_register(RegSkipCount, {junk[63:SkipW], skip});
    if (garble && $urandom_range(3) == 0) write_register(RegSpare, {$urandom, $urandom});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every byte is taken and every report is in, then let the
  // pipeline run dry before touching the registers.
  task automatic settle();
    while (bytes_taken != bytes_queued || pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_phase();
    logic [AddrW-1:0]      base;
    logic [AddrW-1:0]      slen;
    logic [8*PatBytes-1:0] pat;
    logic [PatBytes-1:0]   care;
    logic [SkipW-1:0]      skip;
    logic [PlenW-1:0]      plen;
    logic [7:0]            scan_bytes [MaxScanBytes];
    int unsigned eff, nscans, blen, at, j, k, restart_at;
    bit          lead_first, end_last;

    case ($urandom_range(9))
      0:       plen = 0;
      1:       plen = 5'($urandom_range(31, 17));
      2, 3:    plen = 5'($urandom_range(16, 7));
      default: plen = 5'($urandom_range(6, 1));
    endcase
    eff = (plen == 0) ? 1 : ((plen > MaxPatternDef) ? MaxPatternDef : plen);
    case ($urandom_range(7))
      0:       care = '0;
      1:       care = '1;
      default: care = 16'($urandom);
    endcase
    case ($urandom_range(15))
      0:       skip = '1;
      1:       skip = 16'($urandom);
      default: skip = 16'($urandom_range(3, 0));
    endcase
    case ($urandom_range(15))
      0:       slen = '0;
      1:       slen = '1;
      2, 3:    slen = $urandom;
      default: slen = $urandom_range(60, 1);
    endcase
    case ($urandom_range(7))
      0:       base = '0;
      1:       base = '1;
      default: base = $urandom;
    endcase
    pat = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(3))
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 10; stall_pct = 10; end
      2: begin gap_pct = 40; stall_pct = 5;  end
      default: begin gap_pct = 5; stall_pct = 40; end
    endcase

    program_scan(base, slen, pat[63:0], pat[127:64], care, plen, skip, 1'b1);

    nscans = $urandom_range(6, 2);
    for (int n = 0; n < nscans; n++) begin
      blen = ($urandom_range(9) == 0) ? $urandom_range(MaxScanBytes, 49) : $urandom_range(48, 1);
      // mix pattern bytes with noise, then plant up to three copies of the cared bytes
      for (k = 0; k < blen; k++) begin
        scan_bytes[k] = $urandom_range(1, 0) ? pat[8*$urandom_range(eff - 1, 0) +: 8]
                                             : 8'($urandom);
      end
      repeat ($urandom_range(3, 0)) begin
        at = $urandom_range(blen - 1, 0);
        for (j = 0; j < eff && at + j < blen; j++) begin
          if (care[j]) scan_bytes[at + j] = pat[8*j +: 8];
        end
      end
      // stray byte between scans: dropped when the scanner is idle
      if ($urandom_range(7) == 0) queue_byte(8'($urandom), 1'b0, 1'($urandom_range(1, 0)));
      lead_first = ($urandom_range(31) != 0);
      restart_at = (blen > 1 && $urandom_range(19) == 0) ? $urandom_range(blen - 1, 1) : 0;
      end_last   = (n == nscans - 1) || ($urandom_range(9) != 0);
      for (k = 0; k < blen; k++) begin
        queue_byte(scan_bytes[k],
                   (k == 0 && lead_first) || (restart_at != 0 && k == restart_at),
                   (k == blen - 1) && end_last);
      end
    end
    settle();
  endtask

  initial begin
    logic [63:0] plo;
    logic [63:0] phi;
    int unsigned j;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    gap_pct   = 20;
    stall_pct = 20;

    // reset registers: one-byte wildcard pattern hits at offset zero, then
    // a byte without first is dropped while idle
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    settle();

    // zero scan length fails on the first byte
    program_scan('1, '0, '0, '0, '0, 5'd1, '0, 1'b0);
    queue_byte(8'h5A, 1'b1, 1'b0);
    settle();

    // pattern length zero acts as one; address wraps past the top
    program_scan('1, '1, 64'hAB, '0, 16'h0001, 5'd0, '0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h12, 1'b0, 1'b0);
    queue_byte(8'hAB, 1'b0, 1'b1);
    settle();

    // oversized pattern length clamps to the full window, every byte cared
    plo = 64'hFF00_1234_5678_9ABC;
    phi = 64'h00FF_EDCB_A987_6543;
    program_scan(32'h1000_0000, 32'd1, plo, phi, '1, 5'd31, '0, 1'b0);
    for (j = 0; j < PatBytes; j++) begin
      queue_byte(j < 8 ? plo[8*j +: 8] : phi[8*(j - 8) +: 8], j == 0, j == PatBytes - 1);
    end
    settle();

    // first and last on one byte ends a scan too short for the pattern
    program_scan('0, 32'd4, '0, '0, '0, 5'd2, '0, 1'b0);
    queue_byte(8'h7E, 1'b1, 1'b1);
    settle();

    // skipped matches run out of start offsets; the trailing byte is dropped
    program_scan(32'h20, 32'd2, 64'h11, '0, 16'h0001, 5'd1, 16'd2, 1'b0);
    queue_byte(8'h11, 1'b1, 1'b0);
    queue_byte(8'h11, 1'b0, 1'b0);
    queue_byte(8'h11, 1'b0, 1'b1);
    settle();

    while (bytes_queued < ItemTarget) begin
      if (bytes_queued + CalmMargin >= ItemTarget) calm = 1'b1;
      random_phase();
    end

    if (fail_count == 0) begin
      $display("PASS masked_byte_pattern_scanner");
    end else begin
      $display("FAIL masked_byte_pattern_scanner");
    end
    $finish;
  end

endmodule
